[hw/rtl/pira_pkg.sv]
`default_nettype none

package pira_pkg;

    localparam int unsigned KIND_W  = 2;
    localparam int unsigned POS_W   = 6;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned COUNT_W = 6;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic [COUNT_W-1:0]       count;
        logic signed [DATA_W-1:0] read_value;
    } t_rsp;

    typedef struct packed {
        logic                     ins;
        logic                     rem;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctl;

endpackage

`default_nettype wire

[hw/rtl/pira_if.sv]
`default_nettype none

interface pira_req_if;
    import pira_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pira_rsp_if;
    import pira_pkg::*;

    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/pira_cell.sv]
`default_nettype none

module pira_cell #(
    parameter int unsigned IDX = 0
) (
    input  wire logic                               i_clk,
    input  wire pira_pkg::t_cell_ctl                i_ctl,
    input  wire logic signed [pira_pkg::DATA_W-1:0] i_lower,
    input  wire logic signed [pira_pkg::DATA_W-1:0] i_upper,
    output logic signed [pira_pkg::DATA_W-1:0]      o_data,
    output logic signed [pira_pkg::DATA_W-1:0]      o_sel
);
    import pira_pkg::*;

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;
    logic [31:0]              pos_ext;
    logic                     at_pos;
    logic                     above_pos;

    assign pos_ext   = {{(32-POS_W){1'b0}}, i_ctl.pos};
    assign at_pos    = (pos_ext == 32'(IDX));
    assign above_pos = (32'(IDX) > pos_ext);

    always_comb begin
        n_data = r_data;
        if (i_ctl.ins) begin
            if (at_pos) begin
                n_data = i_ctl.value;
            end else if (above_pos) begin
                n_data = i_lower;
            end
        end else if (i_ctl.rem) begin
            if (at_pos || above_pos) begin
                n_data = i_upper;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_sel  = at_pos ? r_data : '0;

endmodule

`default_nettype wire

[hw/rtl/positional_insert_remove_array.sv]
// positional insert/remove list of signed 32-bit entries
//
// channels: i_req (sink) carries kind, position and value; o_rsp (source)
// carries status, count and read_value. a transaction happens at a rising
// edge with valid and ready both high; every request gives one response.
//
// the response is registered and valid in the cycle after the request.
// throughput: one request per cycle while o_rsp is not stalled. each cell
// picks its own word, its lower or upper neighbor's or the new value in
// the same cycle, so an insert or remove shift moves all cells at once.
//
// the output register frees up as the response is taken, so a new request
// is taken in the same cycle the previous response leaves. while o_rsp is
// stalled i_req.ready stays low and the held response does not change.
//
// reset (i_rst_n low, synchronous) empties the list and drops o_rsp.valid.
// entry contents are not cleared; positions at or above the count are
// never read back.
`default_nettype none

module positional_insert_remove_array #(
    parameter int unsigned CAPACITY = 32
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    pira_req_if.sink    i_req,
    pira_rsp_if.source  o_rsp
);
    import pira_pkg::*;

    localparam int unsigned CW   = $clog2(CAPACITY + 1);
    localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

    logic                     accept;
    logic                     r_out_valid;
    t_rsp                     r_rsp;
    t_rsp                     n_rsp;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    logic [CMPW-1:0]          count_ext;
    logic [CMPW-1:0]          pos_ext;
    logic                     is_full;
    t_cell_ctl                cell_ctl;
    logic signed [DATA_W-1:0] w_data [CAPACITY];
    logic signed [DATA_W-1:0] w_sel  [CAPACITY];
    logic signed [DATA_W-1:0] rd_word;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;

    assign count_ext = CMPW'(r_count);
    assign pos_ext   = CMPW'(i_req.data.position);
    assign is_full   = (r_count == CW'(CAPACITY));

    always_comb begin
        rd_word = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_word = rd_word | w_sel[i];
        end
    end

    always_comb begin
        cell_ctl.ins   = 1'b0;
        cell_ctl.rem   = 1'b0;
        cell_ctl.pos   = i_req.data.position;
        cell_ctl.value = i_req.data.value;
        n_count        = r_count;
        n_rsp.status   = STAT_OK;
        n_rsp.read_value = '0;
        case (i_req.data.kind)
            KIND_INSERT: begin
                if (pos_ext > count_ext) begin
                    n_rsp.status = STAT_BADPOS;
                end else if (is_full) begin
                    n_rsp.status = STAT_FULL;
                end else begin
                    cell_ctl.ins = accept;
                    n_count      = r_count + CW'(1);
                end
            end
            KIND_REMOVE: begin
                if (pos_ext >= count_ext) begin
                    n_rsp.status = STAT_BADPOS;
                end else begin
                    cell_ctl.rem = accept;
                    n_count      = r_count - CW'(1);
                end
            end
            KIND_READ: begin
                if (pos_ext >= count_ext) begin
                    n_rsp.status = STAT_BADPOS;
                end else begin
                    n_rsp.read_value = rd_word;
                end
            end
            default: begin
                n_rsp.status = STAT_OK;
            end
        endcase
        n_rsp.count = COUNT_W'(CMPW'(n_count));
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_W-1:0] lower;
        logic signed [DATA_W-1:0] upper;

        if (g == 0) begin : g_first
            assign lower = '0;
        end else begin : g_mid_lo
            assign lower = w_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign upper = '0;
        end else begin : g_mid_hi
            assign upper = w_data[g+1];
        end

        pira_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl),
            .i_lower (lower),
            .i_upper (upper),
            .o_data  (w_data[g]),
            .o_sel   (w_sel[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_rsp;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_req.data.kind == KIND_INSERT) && (n_rsp.status == STAT_OK)
        |=> r_count == $past(r_count) + CW'(1))
        else $error("insert did not grow the list");

    a_reject_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (n_rsp.status != STAT_OK) |=> $stable(r_count))
        else $error("rejected transaction changed the count");

    a_bad_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_rsp.status != STAT_OK) |-> r_rsp.read_value == '0)
        else $error("nonzero read value on failed transaction");

    a_rsp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("response missing after request");
`endif

endmodule

`default_nettype wire

[dv/tb.sv]
`default_nettype none

module tb;
    import pira_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CAPACITY = 32;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;

    localparam int unsigned MODE_BALANCED = 0;
    localparam int unsigned MODE_GROW = 1;
    localparam int unsigned MODE_SHRINK = 2;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    pira_req_if req_if ();
    pira_rsp_if rsp_if ();

    positional_insert_remove_array #(
        .CAPACITY(CAPACITY)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow copy of the list
    logic signed [DATA_W-1:0] shadow_list [CAPACITY];
    int unsigned shadow_len = 0;
    t_rsp pending_rsp [$];

    int unsigned err_cnt = 0;
    int unsigned idle_pct = 0;
    int unsigned quiet_cycles = 0;
    int unsigned n_ins = 0;
    int unsigned n_rem = 0;
    int unsigned n_rd = 0;
    int unsigned n_other = 0;
    int unsigned n_full = 0;
    int unsigned n_bad = 0;
    int unsigned peak_len = 0;

    function automatic t_rsp apply_list_op(input t_req op);
        t_rsp rsp;
        int unsigned pos;
        pos = 32'(op.position);
        rsp.status = STAT_OK;
        rsp.read_value = '0;
        case (op.kind)
            KIND_INSERT: begin
                n_ins++;
                if (pos > shadow_len) begin
                    rsp.status = STAT_BADPOS;
                end else if (shadow_len >= CAPACITY) begin
                    rsp.status = STAT_FULL;
                end else begin
                    for (int i = shadow_len; i > pos; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[pos] = op.value;
                    shadow_len++;
                    if (shadow_len > peak_len)
                        peak_len = shadow_len;
                end
            end
            KIND_REMOVE: begin
                n_rem++;
                if (pos >= shadow_len) begin
                    rsp.status = STAT_BADPOS;
                end else begin
                    for (int i = pos; i + 1 < shadow_len; i++)
                        shadow_list[i] = shadow_list[i+1];
                    shadow_len--;
                end
            end
            KIND_READ: begin
                n_rd++;
                if (pos >= shadow_len || pos >= CAPACITY)
                    rsp.status = STAT_BADPOS;
                else
                    rsp.read_value = shadow_list[pos];
            end
            default: n_other++;
        endcase
        if (rsp.status == STAT_FULL)
            n_full++;
        if (rsp.status == STAT_BADPOS)
            n_bad++;
        rsp.count = shadow_len[COUNT_W-1:0];
        return rsp;
    endfunction

    // response check, request prediction and watchdog
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (pending_rsp.size() == 0) begin
                    err_cnt++;
                    $error("response with nothing outstanding: status %0d count %0d",
                           rsp_if.data.status, rsp_if.data.count);
                end else begin
                    want = pending_rsp.pop_front();
                    if (rsp_if.data.status !== want.status) begin
                        err_cnt++;
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, rsp_if.data.status);
                    end
                    if (rsp_if.data.count !== want.count) begin
                        err_cnt++;
                        $error("count mismatch: expected %0d, actual %0d",
                               want.count, rsp_if.data.count);
                    end
                    if (rsp_if.data.read_value !== want.read_value) begin
                        err_cnt++;
                        $error("read_value mismatch: expected %0d, actual %0d",
                               want.read_value, rsp_if.data.read_value);
                    end
                end
            end
            if (req_if.valid && req_if.ready)
                pending_rsp.push_back(apply_list_op(req_if.data));
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", quiet_cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

    function automatic int unsigned pick_gap();
        if (idle_pct == 0 || $urandom_range(99) >= idle_pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(30, 8);
        return $urandom_range(3, 1);
    endfunction

    // response-side backpressure
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                rsp_if.ready = 1'b0;
                stall_left--;
            end else begin
                stall_left = pick_gap();
                if (stall_left > 0) begin
                    rsp_if.ready = 1'b0;
                    stall_left--;
                end else begin
                    rsp_if.ready = 1'b1;
                end
            end
        end
    end

    task automatic wait_slot();
        int unsigned gap;
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic drive_op(input logic [KIND_W-1:0] kind, input int unsigned pos,
                            input logic signed [DATA_W-1:0] val);
        t_req op;
        op.kind = kind;
        op.position = pos[POS_W-1:0];
        op.value = val;
        req_if.data = op;
        req_if.valid = 1'b1;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    task automatic send_op(input logic [KIND_W-1:0] kind, input int unsigned pos,
                           input logic signed [DATA_W-1:0] val);
        wait_slot();
        drive_op(kind, pos, val);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (pending_rsp.size() != 0)
            @(negedge i_clk);
    endtask

    function automatic logic signed [DATA_W-1:0] rand_word();
        case ($urandom_range(15))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return '0;
            3: return -1;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_empty_list();
        idle_pct = 0;
        send_op(KIND_READ, 0, 32'sd5);
        send_op(KIND_REMOVE, 0, 32'sd0);
        send_op(KIND_INSERT, 1, 32'sd7);
        send_op(KIND_READ, 63, 32'sd0);
        send_op(KIND_UNUSED, 0, 32'sd0);
        wait_drained();
    endtask

    task automatic test_edge_values();
        idle_pct = 30;
        send_op(KIND_INSERT, 0, WORD_MIN);
        send_op(KIND_INSERT, 0, WORD_MAX);
        send_op(KIND_INSERT, 2, -1);
        send_op(KIND_INSERT, 1, '0);
        send_op(KIND_INSERT, 5, 32'sh5a5a_a5a5);
        for (int i = 0; i < 4; i++)
            send_op(KIND_READ, i, 32'sd0);
        send_op(KIND_UNUSED, 63, WORD_MAX);
        send_op(KIND_REMOVE, 3, 32'sd0);
        send_op(KIND_REMOVE, 0, 32'sd0);
        send_op(KIND_READ, 2, 32'sd0);
        send_op(KIND_REMOVE, 1, 32'sd0);
        send_op(KIND_REMOVE, 0, 32'sd0);
        send_op(KIND_REMOVE, 0, 32'sd0);
        wait_drained();
    endtask

    task automatic test_full_store();
        idle_pct = 20;
        while (shadow_len < CAPACITY) begin
            wait_slot();
            drive_op(KIND_INSERT, $urandom_range(shadow_len), rand_word());
        end
        send_op(KIND_INSERT, CAPACITY, rand_word());
        send_op(KIND_INSERT, 0, rand_word());
        send_op(KIND_INSERT, CAPACITY + 1, rand_word());
        send_op(KIND_INSERT, 63, rand_word());
        send_op(KIND_READ, CAPACITY - 1, 32'sd0);
        send_op(KIND_READ, CAPACITY, 32'sd0);
        send_op(KIND_REMOVE, CAPACITY - 1, 32'sd0);
        send_op(KIND_INSERT, CAPACITY - 1, WORD_MIN);
        send_op(KIND_READ, CAPACITY - 1, 32'sd0);
        wait_drained();
    endtask

    task automatic random_phase(input int unsigned n_ops, input int unsigned mode);
        int unsigned r;
        int unsigned ins_pct;
        int unsigned pos;
        logic [KIND_W-1:0] kind;
        ins_pct = (mode == MODE_GROW) ? 70 : (mode == MODE_SHRINK) ? 20 : 45;
        repeat (n_ops) begin
            wait_slot();
            r = $urandom_range(99);
            if (r < 2)
                kind = KIND_UNUSED;
            else if (r < 2 + ins_pct)
                kind = KIND_INSERT;
            else if ($urandom_range(1) == 0)
                kind = KIND_REMOVE;
            else
                kind = KIND_READ;
            r = $urandom_range(19);
            if (r < 2)
                pos = $urandom_range(63);
            else if (r == 2)
                pos = shadow_len;
            else if (kind == KIND_INSERT)
                pos = $urandom_range(shadow_len);
            else if (shadow_len == 0)
                pos = 0;
            else
                pos = $urandom_range(shadow_len - 1);
            drive_op(kind, pos, rand_word());
        end
    endtask

    task automatic test_random_walk();
        idle_pct = 0;
        random_phase(100, MODE_GROW);
        idle_pct = 30;
        random_phase(100, MODE_BALANCED);
        wait_drained();
        idle_pct = 70;
        random_phase(100, MODE_SHRINK);
        idle_pct = 10;
        random_phase(100, MODE_GROW);
        wait_drained();
        idle_pct = 0;
        random_phase(100, MODE_BALANCED);
        idle_pct = 40;
        random_phase(100, MODE_SHRINK);
        idle_pct = 20;
        random_phase(60, MODE_BALANCED);
        wait_drained();
    endtask

    initial begin
        req_if.valid = 1'b0;
        req_if.data = '0;
        i_rst_n = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_list();
        test_edge_values();
        test_full_store();
        test_random_walk();

        wait_drained();
        repeat (5) @(posedge i_clk);
        $display("requests: %0d insert, %0d remove, %0d read, %0d unused kind",
                 n_ins, n_rem, n_rd, n_other);
        $display("peak fill %0d of %0d, %0d full rejects, %0d bad positions",
                 peak_len, CAPACITY, n_full, n_bad);
        if (err_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
